// ===== rtl/tcgr_pkg.sv =====
// Package for the text console glyph renderer.
// Holds the codes, reset values, glyph geometry and the result type; no dependencies.
`default_nettype none

package tcgr_pkg;

	// Glyph geometry: rows per glyph, pixels per row byte
	localparam int GLYPH_ROWS  = 6;
	localparam int GLYPH_COLS  = 4;
	localparam int ROW_W       = $clog2(GLYPH_ROWS);
	localparam int FONT_DEPTH  = 768;

	// Field widths
	localparam int COORD_W = 12;
	localparam int PITCH_W = 13;
	localparam int WORD_W  = 25;
	localparam int COLOR_W = 32;
	localparam int CFG_W   = 13;

	// Register reset values
	localparam logic [COORD_W-1:0] RST_SCREEN_WIDTH  = 12'd640;
	localparam logic [COORD_W-1:0] RST_SCREEN_HEIGHT = 12'd480;
	localparam logic [PITCH_W-1:0] RST_LINE_WORDS    = 13'd640;
	localparam logic [COORD_W-1:0] RST_MARGIN_SIDE   = 12'd96;
	localparam logic [COORD_W-1:0] RST_MARGIN_BOTTOM = 12'd72;
	localparam logic [COORD_W-1:0] RST_CURSOR_X      = 12'd96;
	localparam logic [COORD_W-1:0] RST_CURSOR_Y      = 12'd72;

	// Character codes
	localparam logic [7:0] CHAR_CR        = 8'd13;
	localparam logic [7:0] CHAR_LF        = 8'd10;
	localparam logic [7:0] CHAR_PRINT_LO  = 8'd32;
	localparam logic [7:0] CHAR_PRINT_END = 8'd127;

	// Input operation codes
	localparam logic FUNC_PRINT = 1'b0;
	localparam logic FUNC_FONT  = 1'b1;

	// Result kinds
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_SCREEN_WIDTH  = 3'd0,
		CFG_SCREEN_HEIGHT = 3'd1,
		CFG_LINE_WORDS    = 3'd2,
		CFG_MARGIN_SIDE   = 3'd3,
		CFG_MARGIN_BOTTOM = 3'd4
	} cfg_reg_t;

	// One result item
	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [WORD_W-1:0]  word;
		logic [COLOR_W-1:0] color;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_glyph_renderer.sv =====
// Text console glyph renderer: cursor, font memory, pixel expansion and scroll commands.
// Depends on tcgr_pkg for codes, reset values and the result type.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  func, char_code, font_addr, font_byte
//   out       output     out_valid/out_stall  kind, pixel_x, pixel_y, word_index, color, last
//   cfg       input      cfg_write            cfg_index, cfg_data
//
// A printable character occupies the glyph sequencer for one slot per pixel of the 6x4
// glyph, one font memory read each, plus a scroll slot if it scrolls; another print code
// that scrolls takes only the scroll slot. A result passes stage 2, the hold stage and
// the output register; the hold stage keeps it until the next result or the end of the
// character is seen, so blank slots behind it delay it further. Reset sets the cursor
// and registers to reset values and clears all valid flags; the font memory is not
// cleared and must be loaded before use. A stalled output freezes the sequencer and the
// pipeline behind it; one item can still be taken while the sequencer is free.
`default_nettype none

module text_console_glyph_renderer #(
	parameter int FONT_DEPTH = tcgr_pkg::FONT_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input item channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          func,
	input  wire logic [7:0]                    char_code,
	input  wire logic [9:0]                    font_addr,
	input  wire logic [7:0]                    font_byte,
	// result item channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               kind,
	output logic [tcgr_pkg::COORD_W-1:0]       pixel_x,
	output logic [tcgr_pkg::COORD_W-1:0]       pixel_y,
	output logic [tcgr_pkg::WORD_W-1:0]        word_index,
	output logic [tcgr_pkg::COLOR_W-1:0]       color,
	output logic                               last,
	// configuration write port
	input  wire logic                          cfg_write,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [tcgr_pkg::CFG_W-1:0]    cfg_data
);

	localparam int AW = $clog2(FONT_DEPTH);
	localparam int CW = tcgr_pkg::COORD_W;
	localparam int RW = tcgr_pkg::ROW_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [CW-1:0]                  screen_width_q;
	logic [CW-1:0]                  screen_height_q;
	logic [tcgr_pkg::PITCH_W-1:0]   line_words_q;
	logic [CW-1:0]                  margin_side_q;
	logic [CW-1:0]                  margin_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= tcgr_pkg::RST_SCREEN_WIDTH;
			screen_height_q <= tcgr_pkg::RST_SCREEN_HEIGHT;
			line_words_q    <= tcgr_pkg::RST_LINE_WORDS;
			margin_side_q   <= tcgr_pkg::RST_MARGIN_SIDE;
			margin_bottom_q <= tcgr_pkg::RST_MARGIN_BOTTOM;
		end else if (cfg_write) begin
			case (cfg_index)
				tcgr_pkg::CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[CW-1:0];
				tcgr_pkg::CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[CW-1:0];
				tcgr_pkg::CFG_LINE_WORDS:    line_words_q    <= cfg_data;
				tcgr_pkg::CFG_MARGIN_SIDE:   margin_side_q   <= cfg_data[CW-1:0];
				tcgr_pkg::CFG_MARGIN_BOTTOM: margin_bottom_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake and pipeline advance
	// ------------------------------------------------------------------
	logic o_valid_q;
	logic adv;          // whole pipeline moves when the output register can take a result
	logic acc;
	logic seq_active_q;
	logic seq_last;

	assign adv      = !o_valid_q || !out_stall;
	// Take a new item when the sequencer is free or finishing its final slot now
	assign in_stall = seq_active_q && !(adv && seq_last);
	assign acc      = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Cursor: updated at accept; the sequencer keeps the old position
	// ------------------------------------------------------------------
	logic [CW-1:0] cursor_x_q, cursor_y_q;
	logic          is_cr, is_lf, is_print;
	logic [CW-1:0] x_adv, x_wrap, y_wrap, y_next, x_next;
	logic          do_wrap, do_scroll, seq_load;

	always_comb begin
		is_cr    = (func == tcgr_pkg::FUNC_PRINT) && (char_code == tcgr_pkg::CHAR_CR);
		is_lf    = (func == tcgr_pkg::FUNC_PRINT) && (char_code == tcgr_pkg::CHAR_LF);
		is_print = (char_code >= tcgr_pkg::CHAR_PRINT_LO)
		        && (char_code <  tcgr_pkg::CHAR_PRINT_END);

		x_adv   = is_print ? cursor_x_q + CW'(tcgr_pkg::GLYPH_COLS) : cursor_x_q;
		do_wrap = (screen_width_q >= margin_side_q)
		       && (x_adv >= screen_width_q - margin_side_q);
		x_wrap  = do_wrap ? margin_side_q : x_adv;
		y_wrap  = do_wrap ? cursor_y_q + CW'(tcgr_pkg::GLYPH_ROWS) : cursor_y_q;

		do_scroll = (screen_height_q >= margin_bottom_q)
		         && (y_wrap >= screen_height_q - margin_bottom_q);

		x_next = cursor_x_q;
		y_next = cursor_y_q;
		if (is_cr) begin
			x_next = margin_side_q;
		end else if (is_lf) begin
			x_next = margin_side_q;
			y_next = cursor_y_q + CW'(tcgr_pkg::GLYPH_ROWS);
		end else begin
			x_next = x_wrap;
			y_next = do_scroll ? y_wrap - CW'(tcgr_pkg::GLYPH_ROWS) : y_wrap;
		end

		// Start the sequencer only for printable characters and for other print codes that scroll
		seq_load = acc && (func == tcgr_pkg::FUNC_PRINT) && !is_cr && !is_lf
		        && (is_print || do_scroll);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= tcgr_pkg::RST_CURSOR_X;
			cursor_y_q <= tcgr_pkg::RST_CURSOR_Y;
		end else if (acc && (func == tcgr_pkg::FUNC_PRINT)) begin
			cursor_x_q <= x_next;
			cursor_y_q <= y_next;
		end
	end

	// ------------------------------------------------------------------
	// Glyph sequencer: one slot per cycle while the output does not stall, row by row,
	// pixel by pixel, then the scroll slot if the character scrolls
	// ------------------------------------------------------------------
	logic [RW-1:0] seq_row_q;
	logic [1:0]    seq_col_q;
	logic          seq_scroll_ph_q;   // issuing the scroll slot
	logic          seq_scroll_q;      // character ends with a scroll
	logic [7:0]    seq_code_q;
	logic [CW-1:0] seq_bx_q, seq_by_q;
	logic          seq_pix_end;

	assign seq_pix_end = (seq_row_q == RW'(tcgr_pkg::GLYPH_ROWS - 1)) && (seq_col_q == '1);
	assign seq_last    = seq_scroll_ph_q || (seq_pix_end && !seq_scroll_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_active_q <= 1'b0;
		end else if (seq_load) begin
			seq_active_q <= 1'b1;
		end else if (adv && seq_active_q && seq_last) begin
			seq_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_load) begin
			seq_row_q       <= '0;
			seq_col_q       <= '0;
			seq_scroll_ph_q <= !is_print;
			seq_scroll_q    <= do_scroll;
			seq_code_q      <= char_code;
			seq_bx_q        <= cursor_x_q;
			seq_by_q        <= cursor_y_q;
		end else if (adv && seq_active_q && !seq_scroll_ph_q) begin
			seq_col_q <= seq_col_q + 2'd1;
			if (seq_col_q == '1) begin
				seq_row_q <= seq_row_q + RW'(1);
			end
			if (seq_pix_end) begin
				seq_scroll_ph_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Font memory: written by font items, read once per pixel slot
	// ------------------------------------------------------------------
	logic [7:0]  font_mem [FONT_DEPTH];
	logic [11:0] rd_idx;
	logic        rd_inrange;
	logic        mem_we, mem_re;
	logic [7:0]  rd_data_s2;

	assign rd_idx     = 12'(seq_code_q) * 12'(tcgr_pkg::GLYPH_ROWS) + 12'(seq_row_q);
	assign rd_inrange = 32'(rd_idx) < FONT_DEPTH;
	assign mem_we     = acc && (func == tcgr_pkg::FUNC_FONT) && (32'(font_addr) < FONT_DEPTH);
	assign mem_re     = adv && seq_active_q && !seq_scroll_ph_q && rd_inrange;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			font_mem[AW'(font_addr)] <= font_byte;
		end
		if (mem_re) begin
			rd_data_s2 <= font_mem[AW'(rd_idx)];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: pick the pixel, bound it, form the word index
	// ------------------------------------------------------------------
	logic          v_s2, pix_s2, end_s2, inr_s2;
	logic [RW-1:0] row_s2;
	logic [1:0]    col_s2;
	logic [CW-1:0] bx_s2, by_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= seq_active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s2 <= !seq_scroll_ph_q;
			end_s2 <= seq_last;
			inr_s2 <= rd_inrange;
			row_s2 <= seq_row_q;
			col_s2 <= seq_col_q;
			bx_s2  <= seq_bx_q;
			by_s2  <= seq_by_q;
		end
	end

	logic [7:0]                   row_byte, shifted;
	logic [7:0]                   grey;
	logic [CW:0]                  px_w, py_w;
	logic [tcgr_pkg::WORD_W-1:0]  prod;
	logic                         emit2;
	tcgr_pkg::res_t               res2;

	always_comb begin
		row_byte = inr_s2 ? rd_data_s2 : 8'd0;
		shifted  = 8'(row_byte << {col_s2, 1'b0});
		grey     = {shifted[7:6], 6'd0};
		px_w     = {1'b0, bx_s2} + (CW+1)'(col_s2);
		py_w     = {1'b0, by_s2} + (CW+1)'(row_s2);
		prod     = tcgr_pkg::WORD_W'(py_w[CW-1:0]) * tcgr_pkg::WORD_W'(line_words_q);

		emit2 = pix_s2 ? ((grey != 8'd0) && (px_w < {1'b0, screen_width_q})
		                  && (py_w < {1'b0, screen_height_q}))
		               : 1'b1;

		if (pix_s2) begin
			res2.kind  = tcgr_pkg::KIND_PIXEL;
			res2.px    = px_w[CW-1:0];
			res2.py    = py_w[CW-1:0];
			res2.word  = tcgr_pkg::WORD_W'(px_w[CW-1:0]) + prod;
			res2.color = {4{grey}};
		end else begin
			res2.kind  = tcgr_pkg::KIND_SCROLL;
			res2.px    = '0;
			res2.py    = '0;
			res2.word  = '0;
			res2.color = '0;
		end
	end

	// ------------------------------------------------------------------
	// Hold stage: keep one result back until it is known whether it is
	// the character's final one, then hand it to the output register
	// ------------------------------------------------------------------
	logic           h_valid_q, h_final_q;
	tcgr_pkg::res_t h_q;
	tcgr_pkg::res_t o_q;
	logic           o_last_q;
	logic           em2, end2, release_h, release_last;

	assign em2          = v_s2 && emit2;
	assign end2         = v_s2 && end_s2;
	assign release_h    = h_valid_q && (h_final_q || em2 || end2);
	assign release_last = h_final_q || (end2 && !em2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			h_final_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else if (adv) begin
			o_valid_q <= release_h;
			if (em2) begin
				h_valid_q <= 1'b1;
				h_final_q <= end2;
			end else if (release_h) begin
				h_valid_q <= 1'b0;
				h_final_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (em2) begin
				h_q <= res2;
			end
			if (release_h) begin
				o_q      <= h_q;
				o_last_q <= release_last;
			end
		end
	end

	assign out_valid  = o_valid_q;
	assign kind       = o_q.kind;
	assign pixel_x    = o_q.px;
	assign pixel_y    = o_q.py;
	assign word_index = o_q.word;
	assign color      = o_q.color;
	assign last       = o_last_q;

`ifndef SYNTHESIS
	// The row counter never runs past the glyph height while pixel slots issue
	assert property (@(posedge clk) disable iff (!arst_n)
		(seq_active_q && !seq_scroll_ph_q) |-> (seq_row_q < RW'(tcgr_pkg::GLYPH_ROWS)))
		else $error("glyph row counter out of range");

	// A scroll slot always closes its character
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !pix_s2) |-> end_s2)
		else $error("scroll slot not marked as final");

	// A final held result goes out next, flagged last
	assert property (@(posedge clk) disable iff (!arst_n)
		(h_valid_q && h_final_q && adv) |=> (out_valid && last))
		else $error("final result not delivered with last");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_text_console_glyph_renderer.sv =====
// Self-checking testbench for the text console glyph renderer.
// Needs tcgr_pkg and text_console_glyph_renderer; a scoreboard class predicts the
// pixel writes and scroll commands and checks every result item in order.
`default_nettype none

module tb_text_console_glyph_renderer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = tcgr_pkg::COORD_W;

	// Cycles to let the glyph sequencer and the result pipeline empty out
	// after the last expected result.
	localparam int SETTLE_CYCLES = 40;
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int MAX_REPORTS   = 10;
	localparam int LONG_HOLD     = 300;

	localparam logic [7:0] CH_HASH  = "#";
	localparam logic [7:0] CH_BANG  = "!";
	localparam logic [7:0] CH_A     = "A";
	localparam logic [7:0] CH_TILDE = "~";
	// Random prints draw from the glyphs below this code, which are all loaded
	localparam logic [7:0] CH_LOADED_END = 8'd48;

	// One input item as the sender offers it
	typedef struct packed {
		logic       func;
		logic [7:0] code;
		logic [9:0] addr;
		logic [7:0] fbyte;
	} char_item_t;

	// One expected result item
	typedef struct packed {
		tcgr_pkg::res_t res;
		logic           last;
	} glyph_write_t;

	// Tracks the cursor, the font and the layout registers, and keeps the
	// results that each accepted character is due to produce.
	class glyph_scoreboard;
		logic [CW-1:0]                width, height, margin_side, margin_bottom;
		logic [tcgr_pkg::PITCH_W-1:0] line_words;
		logic [CW-1:0]                cur_x, cur_y;
		logic [7:0]                   font_rom [tcgr_pkg::FONT_DEPTH];
		glyph_write_t                 due_writes[$];
		int                           mismatches;
		int                           seen;

		function new();
			width         = tcgr_pkg::RST_SCREEN_WIDTH;
			height        = tcgr_pkg::RST_SCREEN_HEIGHT;
			line_words    = tcgr_pkg::RST_LINE_WORDS;
			margin_side   = tcgr_pkg::RST_MARGIN_SIDE;
			margin_bottom = tcgr_pkg::RST_MARGIN_BOTTOM;
			cur_x         = tcgr_pkg::RST_CURSOR_X;
			cur_y         = tcgr_pkg::RST_CURSOR_Y;
			mismatches    = 0;
			seen          = 0;
		endfunction

		function void set_reg(tcgr_pkg::cfg_reg_t idx, logic [tcgr_pkg::CFG_W-1:0] value);
			case (idx)
				tcgr_pkg::CFG_SCREEN_WIDTH:  width         = value[CW-1:0];
				tcgr_pkg::CFG_SCREEN_HEIGHT: height        = value[CW-1:0];
				tcgr_pkg::CFG_LINE_WORDS:    line_words    = value[tcgr_pkg::PITCH_W-1:0];
				tcgr_pkg::CFG_MARGIN_SIDE:   margin_side   = value[CW-1:0];
				tcgr_pkg::CFG_MARGIN_BOTTOM: margin_bottom = value[CW-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return due_writes.size();
		endfunction

		// Note an accepted input item and queue the results it causes
		function void take_item(char_item_t it);
			logic [7:0]         row_bits;
			logic [1:0]         level;
			logic [CW:0]        px, py;
			int unsigned        word_sum;
			glyph_write_t       w;
			int                 n;
			n = 0;
			if (it.func == tcgr_pkg::FUNC_FONT) begin
				// addresses past the store are dropped
				if (it.addr < tcgr_pkg::FONT_DEPTH)
					font_rom[it.addr] = it.fbyte;
				return;
			end
			// CR and LF move the cursor and skip the wrap and scroll checks
			if (it.code == tcgr_pkg::CHAR_CR) begin
				cur_x = margin_side;
				return;
			end
			if (it.code == tcgr_pkg::CHAR_LF) begin
				cur_x = margin_side;
				cur_y = cur_y + CW'(tcgr_pkg::GLYPH_ROWS);
				return;
			end
			if (it.code >= tcgr_pkg::CHAR_PRINT_LO && it.code < tcgr_pkg::CHAR_PRINT_END) begin
				for (int r = 0; r < tcgr_pkg::GLYPH_ROWS; r++) begin
					row_bits = font_rom[int'(it.code) * tcgr_pkg::GLYPH_ROWS + r];
					// keep the carry: a pixel past 4095 is off screen
					py = {1'b0, cur_y} + (CW+1)'(r);
					for (int c = 0; c < tcgr_pkg::GLYPH_COLS; c++) begin
						level = row_bits[7 - 2*c -: 2];
						px = {1'b0, cur_x} + (CW+1)'(c);
						if (level != 2'b00 && px < {1'b0, width}
						    && py < {1'b0, height}) begin
							word_sum = int'(px) + int'(py) * int'(line_words);
							w = '0;
							w.res.kind  = tcgr_pkg::KIND_PIXEL;
							w.res.px    = px[CW-1:0];
							w.res.py    = py[CW-1:0];
							w.res.word  = word_sum[tcgr_pkg::WORD_W-1:0];
							w.res.color = {4{level, 6'b000000}};
							due_writes.push_back(w);
							n++;
						end
					end
				end
				cur_x = cur_x + CW'(tcgr_pkg::GLYPH_COLS);
			end
			// right margin wrap, then bottom margin scroll
			if (width >= margin_side && cur_x >= width - margin_side) begin
				cur_x = margin_side;
				cur_y = cur_y + CW'(tcgr_pkg::GLYPH_ROWS);
			end
			if (height >= margin_bottom && cur_y >= height - margin_bottom) begin
				cur_y = cur_y - CW'(tcgr_pkg::GLYPH_ROWS);
				w = '0;
				w.res.kind = tcgr_pkg::KIND_SCROLL;
				due_writes.push_back(w);
				n++;
			end
			if (n > 0)
				due_writes[due_writes.size() - 1].last = 1'b1;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%s", msg);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				flag($sformatf("result %0d: %s expected %0h got %0h", seen, name, want, got));
		endfunction

		// Compare one accepted result with the oldest expectation
		function void match_result(logic kind, logic [CW-1:0] px, logic [CW-1:0] py,
				logic [tcgr_pkg::WORD_W-1:0] word, logic [tcgr_pkg::COLOR_W-1:0] color,
				logic last);
			glyph_write_t w;
			if (due_writes.size() == 0) begin
				flag($sformatf({"result %0d unexpected: kind %0d x %0d y %0d",
					" word %0h color %0h last %0d"},
					seen, kind, px, py, word, color, last));
			end else begin
				w = due_writes.pop_front();
				check_field("kind", 32'(w.res.kind), 32'(kind));
				check_field("pixel_x", 32'(w.res.px), 32'(px));
				check_field("pixel_y", 32'(w.res.py), 32'(py));
				check_field("word_index", 32'(w.res.word), 32'(word));
				check_field("color", w.res.color, color);
				check_field("last", 32'(w.last), 32'(last));
			end
			seen++;
		endfunction
	endclass

	// Clock, reset and every block input start at known values
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       func      = tcgr_pkg::FUNC_PRINT;
	logic [7:0]                 char_code = 8'h00;
	logic [9:0]                 font_addr = 10'h000;
	logic [7:0]                 font_byte = 8'h00;
	logic                       out_stall = 1'b0;
	logic                       cfg_write = 1'b0;
	tcgr_pkg::cfg_reg_t         cfg_index = tcgr_pkg::CFG_SCREEN_WIDTH;
	logic [tcgr_pkg::CFG_W-1:0] cfg_data  = '0;

	wire logic                          in_stall;
	wire logic                          out_valid;
	wire logic                          kind;
	wire logic [CW-1:0]                 pixel_x;
	wire logic [CW-1:0]                 pixel_y;
	wire logic [tcgr_pkg::WORD_W-1:0]   word_index;
	wire logic [tcgr_pkg::COLOR_W-1:0]  color;
	wire logic                          last;

	glyph_scoreboard sb;

	// Idle rates in percent, and a long receiver hold requested by the main flow
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request  = 0;
	int hold_left     = 0;
	int cycle_count   = 0;

	text_console_glyph_renderer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.char_code  (char_code),
		.font_addr  (font_addr),
		.font_byte  (font_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.word_index (word_index),
		.color      (color),
		.last       (last),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// Receiver: pick up a hold request at the rising edge, drive stall at the
	// falling edge; a hold keeps stall high for its whole length.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Result monitor: every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.match_result(kind, pixel_x, pixel_y, word_index, color, last);
	end

	// Watchdog: end the run if it hangs
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("text_console_glyph_renderer: mismatch");
		$finish;
	end

	function automatic char_item_t print_item(logic [7:0] code);
		char_item_t it;
		it.func  = tcgr_pkg::FUNC_PRINT;
		it.code  = code;
		it.addr  = 10'($urandom);
		it.fbyte = 8'($urandom);
		return it;
	endfunction

	function automatic char_item_t font_item(logic [9:0] addr, logic [7:0] value);
		char_item_t it;
		it.func  = tcgr_pkg::FUNC_FONT;
		it.code  = 8'($urandom);
		it.addr  = addr;
		it.fbyte = value;
		return it;
	endfunction

	// Mostly printable glyphs, some CR/LF, other codes and font rewrites
	function automatic char_item_t random_item();
		char_item_t it;
		int unsigned pick;
		it = print_item(8'($urandom_range(CH_LOADED_END - 1, tcgr_pkg::CHAR_PRINT_LO)));
		pick = $urandom_range(99);
		if (pick >= 62 && pick < 69) begin
			it.code = tcgr_pkg::CHAR_CR;
		end else if (pick >= 69 && pick < 76) begin
			it.code = tcgr_pkg::CHAR_LF;
		end else if (pick >= 76 && pick < 86) begin
			if ($urandom_range(1) != 0)
				it.code = 8'($urandom_range(tcgr_pkg::CHAR_PRINT_LO - 1));
			else
				it.code = 8'($urandom_range(255, tcgr_pkg::CHAR_PRINT_END));
			// push control codes that mean CR or LF to their neighbor
			if (it.code == tcgr_pkg::CHAR_CR || it.code == tcgr_pkg::CHAR_LF)
				it.code = it.code + 8'd1;
		end else if (pick >= 86) begin
			it = font_item(10'($urandom), 8'($urandom));
		end
		return it;
	endfunction

	// Offer one item, starting and ending at a falling edge. Valid stays high
	// after acceptance so the next item can follow without a gap.
	task automatic offer_item(input char_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		func      <= it.func;
		char_code <= it.code;
		font_addr <= it.addr;
		font_byte <= it.fbyte;
		do @(posedge clk); while (in_stall);
		sb.take_item(it);
		@(negedge clk);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			offer_item(random_item());
	endtask

	// Drop valid, wait for every due result, then let the sequencer empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input tcgr_pkg::cfg_reg_t idx,
			input logic [tcgr_pkg::CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.set_reg(idx, value);
		@(negedge clk);
	endtask

	// Write all five layout registers back to back; the block must be idle
	task automatic load_layout(input logic [CW-1:0] w, input logic [CW-1:0] h,
			input logic [tcgr_pkg::PITCH_W-1:0] lw, input logic [CW-1:0] ms,
			input logic [CW-1:0] mb);
		write_reg(tcgr_pkg::CFG_SCREEN_WIDTH, tcgr_pkg::CFG_W'(w));
		write_reg(tcgr_pkg::CFG_SCREEN_HEIGHT, tcgr_pkg::CFG_W'(h));
		write_reg(tcgr_pkg::CFG_LINE_WORDS, tcgr_pkg::CFG_W'(lw));
		write_reg(tcgr_pkg::CFG_MARGIN_SIDE, tcgr_pkg::CFG_W'(ms));
		write_reg(tcgr_pkg::CFG_MARGIN_BOTTOM, tcgr_pkg::CFG_W'(mb));
		cfg_write <= 1'b0;
	endtask

	initial begin
		logic [7:0] glyph_row;
		sb = new();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 31;
		recv_idle_pct = 63;

		// Load every glyph the run prints so no print reads an unwritten entry.
		// A few glyphs get fixed shapes for the directed part.
		for (int code = tcgr_pkg::CHAR_PRINT_LO; code < tcgr_pkg::CHAR_PRINT_END; code++) begin
			if (code >= CH_LOADED_END && code != CH_A && code != CH_TILDE)
				continue;
			for (int r = 0; r < tcgr_pkg::GLYPH_ROWS; r++) begin
				case (8'(code))
					tcgr_pkg::CHAR_PRINT_LO: glyph_row = 8'h00;
					CH_HASH:                 glyph_row = 8'hFF;
					CH_A:                    glyph_row = 8'h1B;
					CH_TILDE:                glyph_row = 8'hE4;
					default:                 glyph_row = 8'($urandom);
				endcase
				offer_item(font_item(10'(code * tcgr_pkg::GLYPH_ROWS + r), glyph_row));
			end
		end

		// Directed part under the reset layout: all grey levels, blank glyph,
		// non-printing codes at both ends, CR, LF, and font writes at the
		// address extremes including one beyond the store.
		offer_item(print_item(CH_A));
		offer_item(print_item(CH_TILDE));
		offer_item(print_item(tcgr_pkg::CHAR_PRINT_LO));
		offer_item(print_item(8'h00));
		offer_item(print_item(tcgr_pkg::CHAR_PRINT_LO - 8'd1));
		offer_item(print_item(tcgr_pkg::CHAR_PRINT_END));
		offer_item(print_item(8'hFF));
		offer_item(print_item(tcgr_pkg::CHAR_CR));
		offer_item(print_item(tcgr_pkg::CHAR_LF));
		offer_item(font_item(10'h3FF, 8'hFF));
		offer_item(font_item(10'(tcgr_pkg::FONT_DEPTH - 1), 8'h00));
		offer_item(font_item(10'h000, 8'hAA));
		offer_item(print_item(CH_HASH));
		offer_item(print_item(CH_BANG));
		settle();

		// Narrow screen: the glyph straddles the right edge, wraps every
		// character and walks off the bottom; height below the bottom margin
		// means no scroll.
		load_layout(12'd98, 12'd100, 13'd8191, 12'd96, 12'd4095);
		offer_item(print_item(tcgr_pkg::CHAR_CR));
		repeat (5) offer_item(print_item(CH_HASH));
		offer_item(print_item(tcgr_pkg::CHAR_LF));
		offer_item(print_item(CH_TILDE));
		settle();

		// First random phase, with one long receiver hold in the middle: keep
		// offering while the output is blocked so the block backs up.
		load_layout(12'd4095, 12'd300, 13'd1000, 12'd40, 12'd60);
		run_random(20);
		hold_request = LONG_HOLD;
		repeat (20) offer_item(print_item(CH_HASH));
		settle();
		run_random(20);
		settle();

		// Width below the side margin (no wrap) and a scroll on every character but CR
		// and LF: the cursor runs up past row zero, and CR parks it at 4095
		// so the next glyph carries the column past 4095.
		send_idle_pct = 63;
		recv_idle_pct = 31;
		load_layout(12'd4000, 12'd4095, 13'd8191, 12'd4095, 12'd4095);
		run_random(32);
		settle();

		// No idling, ordinary wrap, scroll only at the very last row
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_layout(12'd640, 12'd4095, 13'd640, 12'd96, 12'd0);
		run_random(32);
		settle();

		// Full glyph plus a scroll: the most results one character can cause
		load_layout(12'd4095, 12'd4095, 13'd8191, 12'd0, 12'd4095);
		offer_item(print_item(tcgr_pkg::CHAR_CR));
		offer_item(print_item(CH_HASH));
		settle();

		// Everything zero: nothing lands on screen, each character but CR wraps and
		// scrolls
		load_layout(12'd0, 12'd0, 13'd0, 12'd0, 12'd0);
		offer_item(print_item(CH_A));
		offer_item(print_item(8'd200));
		offer_item(print_item(tcgr_pkg::CHAR_CR));
		offer_item(print_item(CH_HASH));
		settle();

		if (sb.mismatches == 0)
			$display("text_console_glyph_renderer: match");
		else
			$display("text_console_glyph_renderer: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
